// ----- sv/sife_pkg.sv -----
// Shared types and constants for the stuffed information frame encoder.
// No dependencies; imported by every module of the block.
package sife_pkg;

  localparam logic [7:0] SUB_FLAG = 8'h5e;
  localparam logic [7:0] SUB_ESC  = 8'h5d;

  // Configuration register indexes.
  localparam logic [2:0] REG_FLAG   = 3'd0;
  localparam logic [2:0] REG_ESCAPE = 3'd1;
  localparam logic [2:0] REG_ADDR   = 3'd2;
  localparam logic [2:0] REG_CTRL0  = 3'd3;
  localparam logic [2:0] REG_CTRL1  = 3'd4;

  localparam logic [7:0] RST_FLAG   = 8'h7e;
  localparam logic [7:0] RST_ESCAPE = 8'h7d;
  localparam logic [7:0] RST_ADDR   = 8'h03;
  localparam logic [7:0] RST_CTRL0  = 8'h00;
  localparam logic [7:0] RST_CTRL1  = 8'h40;

  // Back end sequencer steps.
  localparam logic [2:0] ST_START = 3'd0;
  localparam logic [2:0] ST_FLAG  = 3'd1;
  localparam logic [2:0] ST_ADDR  = 3'd2;
  localparam logic [2:0] ST_CTRL  = 3'd3;
  localparam logic [2:0] ST_HCHK  = 3'd4;
  localparam logic [2:0] ST_DATA  = 3'd5;
  localparam logic [2:0] ST_PCHK  = 3'd6;
  localparam logic [2:0] ST_CFLAG = 3'd7;

  // One classified payload byte, as queued between front and back.
  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       seq;
    logic [7:0] pchk;
  } sife_item_t;

  typedef struct packed {
    logic [7:0] flag;
    logic [7:0] escape;
    logic [7:0] addr;
    logic [7:0] ctrl0;
    logic [7:0] ctrl1;
  } sife_cfg_t;

endpackage

// ----- sv/stuffed_info_frame_encoder.sv -----
// Top level of the stuffed information frame encoder.
// Depends on sife_pkg, sife_front, sife_queue and sife_back.
//
// Usage: each input word carries one payload byte with first, last and
// sequence marks. A word is taken when in_valid is high and in_stall is low.
// A first word produces the opening flag, address, control byte (picked by
// the sequence bit) and header check, then its payload byte; a last word adds
// the payload check and the closing flag. All bytes between the flags are
// stuffed, so one field can take two line bytes. Words outside a frame are
// dropped without output.
// Results leave one line byte per cycle on out_byte while not stalled, taken
// when out_valid is high and out_stall is low. out_run_end marks the final
// byte of a word and out_frame_end marks the closing flag.
// With the back end idle, a taken word is written into the queue and its first
// byte is then loaded into the output register.
// The output sequencer sends one line byte per cycle while out_stall is low;
// a plain payload byte gives one line byte, an escaped one two, and the
// header and trailer fields add their line bytes to first and last words.
// A two-word queue lets the front keep taking words meanwhile.
// A stalled receiver holds the output register; the queue fills and then
// in_stall rises. Reset empties the queue, closes any frame and loads the
// register defaults.
module stuffed_info_frame_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_payload_byte,
  input  logic       in_first_byte,
  input  logic       in_last_byte,
  input  logic       in_seq_bit,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_run_end,
  output logic       out_frame_end,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_wdata
);
  import sife_pkg::*;

  sife_cfg_t  cfg_r;
  sife_item_t push_item, head_item;
  logic       push, pop, q_full, head_valid;

  // Configuration registers; writes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flag   <= RST_FLAG;
      cfg_r.escape <= RST_ESCAPE;
      cfg_r.addr   <= RST_ADDR;
      cfg_r.ctrl0  <= RST_CTRL0;
      cfg_r.ctrl1  <= RST_CTRL1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FLAG:   cfg_r.flag   <= cfg_wdata;
        REG_ESCAPE: cfg_r.escape <= cfg_wdata;
        REG_ADDR:   cfg_r.addr   <= cfg_wdata;
        REG_CTRL0:  cfg_r.ctrl0  <= cfg_wdata;
        REG_CTRL1:  cfg_r.ctrl1  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The front classifies words and keeps the running payload check.
  sife_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .q_full       (q_full),
    .payload_byte (in_payload_byte),
    .first_byte   (in_first_byte),
    .last_byte    (in_last_byte),
    .seq_bit      (in_seq_bit),
    .in_stall     (in_stall),
    .push         (push),
    .push_item    (push_item)
  );

  sife_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  // The back walks the frame fields of the head word, one line byte a cycle unless stalled.
  sife_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .head_valid    (head_valid),
    .head_item     (head_item),
    .pop           (pop),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_byte      (out_byte),
    .out_run_end   (out_run_end),
    .out_frame_end (out_frame_end)
  );

endmodule

// ----- sv/sife_front.sv -----
// Front end: accepts input words, tracks frame state and the payload check.
// Depends on sife_pkg; feeds sife_queue.
module sife_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              q_full,
  input  logic [7:0]        payload_byte,
  input  logic              first_byte,
  input  logic              last_byte,
  input  logic              seq_bit,
  output logic              in_stall,
  output logic              push,
  output sife_pkg::sife_item_t push_item
);
  import sife_pkg::*;

  logic       open_r, open_nxt;
  logic [7:0] chk_r, chk_nxt;
  logic [7:0] chk_new;
  logic       accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  // Bytes outside any frame are dropped here and never reach the back end.
  assign push     = accept && (first_byte || open_r);
  assign chk_new  = first_byte ? payload_byte : (chk_r ^ payload_byte);

  assign push_item.data  = payload_byte;
  assign push_item.first = first_byte;
  assign push_item.last  = last_byte;
  assign push_item.seq   = seq_bit;
  assign push_item.pchk  = chk_new;

  always_comb begin
    open_nxt = open_r;
    chk_nxt  = chk_r;
    if (push) begin
      open_nxt = !last_byte;
      chk_nxt  = last_byte ? 8'h00 : chk_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      chk_r  <= 8'h00;
    end else begin
      open_r <= open_nxt;
      chk_r  <= chk_nxt;
    end
  end

endmodule

// ----- sv/sife_queue.sv -----
// Two-entry queue of classified words between the front and back ends.
// Depends on sife_pkg.
module sife_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sife_pkg::sife_item_t push_item,
  input  logic              pop,
  output logic              full,
  output logic              head_valid,
  output sife_pkg::sife_item_t head_item
);
  import sife_pkg::*;

  sife_item_t mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_item  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

endmodule

// ----- sv/sife_back.sv -----
// Back end: sequences the line bytes of each queued word, applies byte
// stuffing and drives the output register. Depends on sife_pkg.
module sife_back (
  input  logic              clk,
  input  logic              rst_n,
  input  sife_pkg::sife_cfg_t cfg,
  input  logic              head_valid,
  input  sife_pkg::sife_item_t head_item,
  output logic              pop,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [7:0]        out_byte,
  output logic              out_run_end,
  output logic              out_frame_end
);
  import sife_pkg::*;

  logic [2:0] step_r, step_nxt, cur;
  logic       esc_r, esc_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       run_end_r, run_end_nxt;
  logic       fend_r, fend_nxt;
  logic [7:0] ctrl, fb;
  logic       raw, need_esc, field_done, item_done, can_load, fire;
  logic [2:0] next_step;

  assign can_load = !valid_r || !out_stall;
  assign fire     = can_load && head_valid;
  assign ctrl     = head_item.seq ? cfg.ctrl1 : cfg.ctrl0;
  assign cur      = (step_r == ST_START) ? (head_item.first ? ST_FLAG : ST_DATA) : step_r;

  always_comb begin
    case (cur)
      ST_FLAG:  fb = cfg.flag;
      ST_ADDR:  fb = cfg.addr;
      ST_CTRL:  fb = ctrl;
      ST_HCHK:  fb = cfg.addr ^ ctrl;
      ST_DATA:  fb = head_item.data;
      ST_PCHK:  fb = head_item.pchk;
      ST_CFLAG: fb = cfg.flag;
      default:  fb = head_item.data;
    endcase
  end

  assign raw      = (cur == ST_FLAG) || (cur == ST_CFLAG);
  assign need_esc = !raw && ((fb == cfg.flag) || (fb == cfg.escape));

  always_comb begin
    case (cur)
      ST_FLAG:  next_step = ST_ADDR;
      ST_ADDR:  next_step = ST_CTRL;
      ST_CTRL:  next_step = ST_HCHK;
      ST_HCHK:  next_step = ST_DATA;
      ST_DATA:  next_step = head_item.last ? ST_PCHK : ST_START;
      ST_PCHK:  next_step = ST_CFLAG;
      default:  next_step = ST_START;
    endcase
  end

  assign field_done = esc_r || !need_esc;
  assign item_done  = field_done && (next_step == ST_START);
  assign pop        = fire && item_done;

  always_comb begin
    step_nxt    = step_r;
    esc_nxt     = esc_r;
    byte_nxt    = byte_r;
    run_end_nxt = run_end_r;
    fend_nxt    = fend_r;
    valid_nxt   = valid_r;
    if (can_load) begin
      valid_nxt = fire;
    end
    if (fire) begin
      if (esc_r) begin
        byte_nxt = (fb == cfg.flag) ? SUB_FLAG : SUB_ESC;
      end else if (need_esc) begin
        byte_nxt = cfg.escape;
      end else begin
        byte_nxt = fb;
      end
      esc_nxt     = !field_done;
      step_nxt    = field_done ? next_step : cur;
      run_end_nxt = item_done;
      fend_nxt    = (cur == ST_CFLAG);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= ST_START;
      esc_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      step_r  <= step_nxt;
      esc_r   <= esc_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r    <= byte_nxt;
    run_end_r <= run_end_nxt;
    fend_r    <= fend_nxt;
  end

  assign out_valid     = valid_r;
  assign out_byte      = byte_r;
  assign out_run_end   = run_end_r;
  assign out_frame_end = fend_r;

endmodule
